[design/chd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types, constants and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam int DEF_MAX_LINE_LEN = 64;
  localparam int DEF_SIZE_BITS    = 32;

  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_SP = 8'h20;

  typedef enum logic [2:0] {
    PH_SIZE     = 3'd0,
    PH_DATA     = 3'd1,
    PH_CR       = 3'd2,
    PH_LF       = 3'd3,
    PH_DONE     = 3'd4,
    PH_ERR_SIZE = 3'd5,
    PH_ERR_LONG = 3'd6,
    PH_ERR_CRLF = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_FRAME    = 3'd0,
    ST_PAYLOAD  = 3'd1,
    ST_COMPLETE = 3'd2,
    ST_BAD_SIZE = 3'd3,
    ST_TOO_LONG = 3'd4,
    ST_NO_CRLF  = 3'd5,
    ST_IGNORED  = 3'd6
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] payload_byte;
    logic       chunk_last;
  } chd_result_t;

  // Returns {is_hex, nibble} for one ASCII byte.
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

[design/chd_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chd_core
// Framing state and the per-byte decode step of the chunked body decoder.
// ----------------------------------------------------------------------------
module chd_core #(
  parameter int MAX_LINE_LEN = chd_pkg::DEF_MAX_LINE_LEN,
  parameter int SIZE_BITS    = chd_pkg::DEF_SIZE_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [7:0]          in_byte,
  output chd_pkg::chd_result_t result
);
  import chd_pkg::*;

  localparam int LCW = $clog2(MAX_LINE_LEN + 1);

  phase_t                 phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]   chunk_length_r, chunk_length_nxt;
  logic [SIZE_BITS-1:0]   bytes_received_r, bytes_received_nxt;
  logic [LCW-1:0]         line_count_r, line_count_nxt;
  logic                   digit_seen_r, digit_seen_nxt;
  logic                   digits_stopped_r, digits_stopped_nxt;
  logic                   cr_pending_r, cr_pending_nxt;

  logic [4:0]             hex;
  logic                   too_long;
  logic                   line_end;
  logic                   size_ovf;
  logic                   digit_ok;
  logic [SIZE_BITS-1:0]   bytes_inc;
  logic                   last_data;

  assign hex       = hex_decode(in_byte);
  assign too_long  = (line_count_r == LCW'(MAX_LINE_LEN));
  assign line_end  = cr_pending_r && (in_byte == BYTE_LF);
  assign digit_ok  = !digits_stopped_r && hex[4];
  assign size_ovf  = digit_ok && (chunk_length_r[SIZE_BITS-1 -: 4] != 4'd0);
  assign bytes_inc = bytes_received_r + SIZE_BITS'(1);
  assign last_data = (bytes_inc == chunk_length_r);

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_SIZE: begin
        if (too_long) begin
          phase_nxt = PH_ERR_LONG;
        end else if (line_end) begin
          if (!digit_seen_r) begin
            phase_nxt = PH_ERR_SIZE;
          end else begin
            phase_nxt = (chunk_length_r == '0) ? PH_CR : PH_DATA;
          end
        end else if (size_ovf) begin
          phase_nxt = PH_ERR_SIZE;
        end
      end
      PH_DATA: begin
        if (last_data) phase_nxt = PH_CR;
      end
      PH_CR: begin
        phase_nxt = (in_byte == BYTE_CR) ? PH_LF : PH_ERR_CRLF;
      end
      PH_LF: begin
        if (in_byte != BYTE_LF) begin
          phase_nxt = PH_ERR_CRLF;
        end else if (chunk_length_r == '0) begin
          phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_SIZE;
        end
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // Result item and datapath updates.
  always_comb begin
    result.status       = ST_FRAME;
    result.payload_byte = 8'd0;
    result.chunk_last   = 1'b0;
    chunk_length_nxt    = chunk_length_r;
    bytes_received_nxt  = bytes_received_r;
    line_count_nxt      = line_count_r;
    digit_seen_nxt      = digit_seen_r;
    digits_stopped_nxt  = digits_stopped_r;
    cr_pending_nxt      = cr_pending_r;
    unique case (phase_r)
      PH_SIZE: begin
        if (too_long) begin
          result.status = ST_TOO_LONG;
        end else if (line_end) begin
          if (!digit_seen_r) begin
            result.status = ST_BAD_SIZE;
          end else begin
            line_count_nxt     = '0;
            digit_seen_nxt     = 1'b0;
            digits_stopped_nxt = 1'b0;
            cr_pending_nxt     = 1'b0;
            bytes_received_nxt = '0;
          end
        end else begin
          line_count_nxt = line_count_r + LCW'(1);
          cr_pending_nxt = (in_byte == BYTE_CR);
          if (size_ovf) begin
            result.status = ST_BAD_SIZE;
          end else if (digit_ok) begin
            chunk_length_nxt = {chunk_length_r[SIZE_BITS-5:0], hex[3:0]};
            digit_seen_nxt   = 1'b1;
          end else if (!digits_stopped_r && !(in_byte == BYTE_SP && !digit_seen_r)) begin
            digits_stopped_nxt = 1'b1;
          end
        end
      end
      PH_DATA: begin
        result.status       = ST_PAYLOAD;
        result.payload_byte = in_byte;
        result.chunk_last   = last_data;
        bytes_received_nxt  = bytes_inc;
      end
      PH_CR: begin
        if (in_byte != BYTE_CR) result.status = ST_NO_CRLF;
      end
      PH_LF: begin
        if (in_byte != BYTE_LF) begin
          result.status = ST_NO_CRLF;
        end else if (chunk_length_r == '0) begin
          result.status = ST_COMPLETE;
        end else begin
          chunk_length_nxt   = '0;
          bytes_received_nxt = '0;
          line_count_nxt     = '0;
          digit_seen_nxt     = 1'b0;
          digits_stopped_nxt = 1'b0;
          cr_pending_nxt     = 1'b0;
        end
      end
      PH_DONE:     result.status = ST_IGNORED;
      PH_ERR_SIZE: result.status = ST_BAD_SIZE;
      PH_ERR_LONG: result.status = ST_TOO_LONG;
      default:     result.status = ST_NO_CRLF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_SIZE;
      chunk_length_r   <= '0;
      bytes_received_r <= '0;
      line_count_r     <= '0;
      digit_seen_r     <= 1'b0;
      digits_stopped_r <= 1'b0;
      cr_pending_r     <= 1'b0;
    end else if (step_en) begin
      phase_r          <= phase_nxt;
      chunk_length_r   <= chunk_length_nxt;
      bytes_received_r <= bytes_received_nxt;
      line_count_r     <= line_count_nxt;
      digit_seen_r     <= digit_seen_nxt;
      digits_stopped_r <= digits_stopped_nxt;
      cr_pending_r     <= cr_pending_nxt;
    end
  end

  // Error and done phases never leave until reset.
  a_terminal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE || phase_r == PH_ERR_SIZE || phase_r == PH_ERR_LONG ||
     phase_r == PH_ERR_CRLF) |=> phase_r == $past(phase_r))
    else $error("terminal phase was left");

  // While forwarding payload the count stays below the chunk size.
  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> bytes_received_r < chunk_length_r)
    else $error("payload count reached chunk size in data phase");

  // The size line counter never exceeds the line capacity.
  a_line_count: assert property (@(posedge clk) disable iff (!rst_n)
    line_count_r <= LCW'(MAX_LINE_LEN))
    else $error("size line counter overran capacity");

  // The size line state is clear whenever payload is being forwarded.
  a_digit_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (!digit_seen_r && line_count_r == '0))
    else $error("size line state not cleared before payload");

endmodule

[design/http_chunked_body_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// HTTP/1.1 chunked body decoder, one body byte in and one result item out.
// ----------------------------------------------------------------------------
// The block takes one byte of a chunked body per item and returns one result
// item per byte: a status code, the payload byte when the status is payload,
// and a flag on the last payload byte of each chunk. It sustains one item per
// clock cycle while out_ready is held high; an item passes an input register
// and then the result register, from which its result is presented.
// Ready follows out_ready combinationally through the two stages. Errors are
// sticky until reset, and after the body completes every further byte
// reports ignored.
module http_chunked_body_decoder #(
  parameter int MAX_LINE_LEN = chd_pkg::DEF_MAX_LINE_LEN,
  parameter int SIZE_BITS    = chd_pkg::DEF_SIZE_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_status,
  output logic [7:0] out_payload_byte,
  output logic       out_chunk_last
);
  import chd_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        out_valid_r, out_valid_nxt;
  chd_result_t out_r;
  chd_result_t step_res;
  logic        out_load;
  logic        s1_adv;
  logic        in_fire;

  assign out_load = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && out_load;
  assign in_ready = !s1_valid_r || out_load;
  assign in_fire  = in_valid && in_ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  chd_core #(
    .MAX_LINE_LEN(MAX_LINE_LEN),
    .SIZE_BITS   (SIZE_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(s1_adv),
    .in_byte(s1_byte_r),
    .result (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_byte_r <= in_byte;
    if (s1_adv) out_r <= step_res;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_payload_byte = out_r.payload_byte;
  assign out_chunk_last   = out_r.chunk_last;

endmodule
